>>> design/deadline_timer_queue_core_defines.svh
// Assertion helpers used by the assertion checker of the timer queue.
`ifndef DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is held low.
`define DTQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked in reset as well.
`define DTQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/dtq_pkg.sv
`default_nettype none

package dtq_pkg;

    localparam int ID_COUNT = 16;
    localparam int ID_W     = 4;
    localparam int TIME_W   = 64;
    localparam int CNT_W    = $clog2(ID_COUNT + 1);
    localparam logic [ID_W-1:0] LAST_IDX = ID_W'(ID_COUNT - 1);

    localparam logic [1:0] ACT_SCHEDULE = 2'd0;
    localparam logic [1:0] ACT_CANCEL   = 2'd1;
    localparam logic [1:0] ACT_DISPATCH = 2'd2;

    typedef struct packed {
        logic            load;
        logic            apply;
        logic            scan_clr;
        logic            rd_en;
        logic [ID_W-1:0] rd_idx;
        logic            remove;
        logic            emit;
        logic            emit_fired;
        logic            emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic is_dispatch;
        logic found;
        logic due;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> design/deadline_timer_queue_core.sv
// Flow: after start is accepted the block applies the action and scans the timer table, then
// shows a result strobe; a dispatch that fires shows each fired timer after a further rescan,
// since every result costs one 16-entry scan of the timer table, one entry per cycle.
// Busy is low during the final strobe, so the next item can be accepted while the final result
// is shown, and no new item is taken before the previous one is through. The receiver cannot
// stall. Synchronous active-low reset empties the table and sets the sequence counter to one.
`default_nettype none

module deadline_timer_queue_core
    import dtq_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_action,
    input  wire logic [ID_W-1:0]   i_timer_id,
    input  wire logic [TIME_W-1:0] i_deadline_time,
    input  wire logic [TIME_W-1:0] i_current_time,
    output logic                   o_valid,
    output logic                   o_fired,
    output logic [ID_W-1:0]        o_fired_id,
    output logic                   o_table_full,
    output logic [TIME_W-1:0]      o_earliest_deadline,
    output logic                   o_last
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dtq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    dtq_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_action            (i_action),
        .i_timer_id          (i_timer_id),
        .i_deadline_time     (i_deadline_time),
        .i_current_time      (i_current_time),
        .o_valid             (o_valid),
        .o_fired             (o_fired),
        .o_fired_id          (o_fired_id),
        .o_table_full        (o_table_full),
        .o_earliest_deadline (o_earliest_deadline),
        .o_last              (o_last)
    );

endmodule

`default_nettype wire

>>> design/dtq_ctrl.sv
`default_nettype none

module dtq_ctrl
    import dtq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_APPLY  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_DECIDE = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [ID_W-1:0] r_cnt, n_cnt;
    logic            r_chain, n_chain;

    assign busy = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_chain = r_chain;
        o_cmd   = '0;
        o_cmd.rd_idx = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_chain    = 1'b0;
                    n_state    = ST_APPLY;
                end
            end
            ST_APPLY: begin
                o_cmd.apply    = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_cnt          = '0;
                n_state        = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!i_stat.is_dispatch) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    // A removed timer is reported only after the rescan, which
                    // yields both the remaining minimum and whether more are due.
                    if (r_chain) begin
                        o_cmd.emit       = 1'b1;
                        o_cmd.emit_fired = 1'b1;
                        o_cmd.emit_last  = !i_stat.due;
                    end else if (!i_stat.due) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                    end
                    if (i_stat.due) begin
                        o_cmd.remove   = 1'b1;
                        o_cmd.scan_clr = 1'b1;
                        n_chain        = 1'b1;
                        n_cnt          = '0;
                        n_state        = ST_SCAN;
                    end else begin
                        n_chain = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_chain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_chain <= n_chain;
        end
    end

endmodule

`default_nettype wire

>>> design/dtq_datapath.sv
`default_nettype none

module dtq_datapath
    import dtq_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_stat               o_stat,
    input  wire logic [1:0]        i_action,
    input  wire logic [ID_W-1:0]   i_timer_id,
    input  wire logic [TIME_W-1:0] i_deadline_time,
    input  wire logic [TIME_W-1:0] i_current_time,
    output logic                   o_valid,
    output logic                   o_fired,
    output logic [ID_W-1:0]        o_fired_id,
    output logic                   o_table_full,
    output logic [TIME_W-1:0]      o_earliest_deadline,
    output logic                   o_last
);

    // Timer table storage, indexed by timer id.
    logic [TIME_W-1:0] mem_deadline [ID_COUNT];
    logic [TIME_W-1:0] mem_sequence [ID_COUNT];

    logic [ID_COUNT-1:0] r_valid;
    logic [CNT_W-1:0]    r_count;
    logic [TIME_W-1:0]   r_seq;

    logic [1:0]        r_action;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_deadline;
    logic [TIME_W-1:0] r_now;
    logic              r_full;

    logic              r_cmp_en;
    logic              r_rd_vld;
    logic [ID_W-1:0]   r_rd_idx;
    logic [TIME_W-1:0] r_rd_dl;
    logic [TIME_W-1:0] r_rd_seq;

    logic              r_found;
    logic [ID_W-1:0]   r_best_idx;
    logic [TIME_W-1:0] r_best_dl;
    logic [TIME_W-1:0] r_best_seq;
    logic [ID_W-1:0]   r_fire_id;

    logic sched_full;
    logic sched_write;
    logic better;

    assign sched_full  = !r_valid[r_id] && (32'(r_count) >= NUM_TIMERS);
    assign sched_write = i_cmd.apply && (r_action == ACT_SCHEDULE) && !sched_full;

    // Strict ordering keeps the lower id on a full tie, since ids are scanned upward.
    assign better = r_rd_vld && (!r_found || (r_rd_dl < r_best_dl) ||
                    ((r_rd_dl == r_best_dl) && (r_rd_seq < r_best_seq)));

    assign o_stat.is_dispatch = (r_action == ACT_DISPATCH);
    assign o_stat.found       = r_found;
    assign o_stat.due         = r_found && (r_best_dl <= r_now);

    always_ff @(posedge i_clk) begin
        if (sched_write) begin
            mem_deadline[r_id] <= r_deadline;
            mem_sequence[r_id] <= r_seq;
        end
        if (i_cmd.rd_en) begin
            r_rd_dl  <= mem_deadline[i_cmd.rd_idx];
            r_rd_seq <= mem_sequence[i_cmd.rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= i_action;
            r_id       <= i_timer_id;
            r_deadline <= i_deadline_time;
            r_now      <= i_current_time;
        end
        if (i_cmd.apply) begin
            r_full <= (r_action == ACT_SCHEDULE) && sched_full;
        end
        if (i_cmd.rd_en) begin
            r_rd_vld <= r_valid[i_cmd.rd_idx];
            r_rd_idx <= i_cmd.rd_idx;
        end
        if (r_cmp_en && better) begin
            r_best_idx <= r_rd_idx;
            r_best_dl  <= r_rd_dl;
            r_best_seq <= r_rd_seq;
        end
        if (i_cmd.remove) begin
            r_fire_id <= r_best_idx;
        end
        o_fired             <= i_cmd.emit_fired;
        o_fired_id          <= i_cmd.emit_fired ? r_fire_id : '0;
        o_table_full        <= i_cmd.emit_fired ? 1'b0 : r_full;
        o_earliest_deadline <= r_found ? r_best_dl : '1;
        o_last              <= i_cmd.emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_count  <= '0;
            r_seq    <= TIME_W'(1);
            r_cmp_en <= 1'b0;
            r_found  <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            o_valid  <= i_cmd.emit;
            r_cmp_en <= i_cmd.rd_en;
            if (i_cmd.scan_clr) begin
                r_found <= 1'b0;
            end else if (r_cmp_en && better) begin
                r_found <= 1'b1;
            end
            if (sched_write) begin
                r_valid[r_id] <= 1'b1;
                r_seq         <= r_seq + 1'b1;
                if (!r_valid[r_id]) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (i_cmd.apply && (r_action == ACT_CANCEL)) begin
                r_valid[r_id] <= 1'b0;
                if (r_valid[r_id]) begin
                    r_count <= r_count - 1'b1;
                end
            end else if (i_cmd.remove) begin
                r_valid[r_best_idx] <= 1'b0;
                r_count             <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/dtq_checker.sv
`default_nettype none
`include "deadline_timer_queue_core_defines.svh"

module dtq_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire logic o_fired,
    input wire logic o_table_full,
    input wire logic o_last
);

    // An accepted item keeps the block busy and cannot produce a result at once.
    `DTQ_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (start && !busy) |=> (busy && !o_valid), "accepted item did not make the block busy")

    // The block is free again exactly when the final result of an item is shown.
    `DTQ_ASSERT(a_last_frees, i_clk, i_rst_n, o_valid |-> (o_last == !busy), "last flag and busy disagree")

    // Only a fired result may be followed by more results of the same item.
    `DTQ_ASSERT(a_unfired_is_last, i_clk, i_rst_n, (o_valid && !o_fired) |-> o_last, "non-fired result not marked last")

    // A fired timer comes from a dispatch, which never reports a full table.
    `DTQ_ASSERT(a_fired_not_full, i_clk, i_rst_n, (o_valid && o_fired) |-> !o_table_full, "fired result flags a full table")

    // Results are single-cycle strobes separated by scan time.
    `DTQ_ASSERT_ALWAYS(a_strobe_single, i_clk, (i_rst_n && $past(i_rst_n) && $past(o_valid)) |-> !o_valid, "result strobe lasted more than one cycle")

endmodule

bind deadline_timer_queue_core dtq_checker u_dtq_checker (.*);

`default_nettype wire
